// ===== hdl/wpsu_pkg.sv =====
package wpsu_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int COORD_W  = 32;
  localparam int SPEED_W  = 31;
  localparam int TRIM_W   = 7;
  localparam int SEC_W    = 6;
  localparam int REQ_W    = 2;
  localparam int LANES    = 3;

  localparam int DIFF_W   = COORD_W + 1;
  localparam int ACC_W    = 70;
  localparam int ROOT_W   = ACC_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int DIV_W    = 64;
  localparam int DREM_W   = ROOT_W;
  localparam int STEP_W   = 36;

  localparam int S_DATA_W = 232;
  localparam int M_DATA_W = 104;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRIM  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

endpackage

// ===== hdl/waypoint_path_stepper_unit.sv =====
// channel | dir | tdata (low bit up)                                       | tuser
// s_axis  | in  | point_x,y,z[95:0] pos_x,y,z[191:96] move_speed[222:192]   | req_type
//         |     | trim_count[229:223], zero fill                            |
// m_axis  | out | out_x,y,z[95:0] reached_end[96] current_section[102:97]   | -
//         |     | path_valid[103]                                           |
// Load, trim, clear and a move without a valid section go from idle straight to done.
// A move runs three 33-step bit-serial multiplies, the 35-step square root and the
// 64-step restoring division; a zero section length ends it after the square root.
// Reset clears counts and section index; table contents stay undefined.
// A finished result waits in the output register while the next word is taken.
module waypoint_path_stepper_unit
  import wpsu_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // point_x, point_y, point_z, pos_x, pos_y,
                                             // pos_z, move_speed, trim_count
  input  logic [REQ_W-1:0]    s_axis_tuser,  // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // out_x, out_y, out_z, reached_end,
                                             // current_section, path_valid
);

  localparam int IDXW = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int TW   = (CW > TRIM_W) ? CW : TRIM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic [1:0] SEL_SQ  = 2'd0;
  localparam logic [1:0] SEL_SPD = 2'd1;
  localparam logic [1:0] SEL_DOT = 2'd2;

  localparam logic [5:0] MUL_LAST  = 6'(DIFF_W - 1);
  localparam logic [5:0] SQRT_LAST = 6'(ROOT_W - 1);
  localparam logic [5:0] DIV_LAST  = 6'(DIV_W - 1);

  logic [REQ_W-1:0]   req;
  logic [COORD_W-1:0] in_pt  [LANES];
  logic [COORD_W-1:0] in_pos [LANES];
  logic [SPEED_W-1:0] in_spd;
  logic [TRIM_W-1:0]  in_trim;

  logic [3:0]      state_q, state_d;
  logic [1:0]      sel_q;
  logic [5:0]      cnt_q;
  logic [CW-1:0]   pcnt_q, scnt_q;
  logic [IDXW-1:0] sidx_q;
  logic            m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  logic [COORD_W-1:0] e_q    [LANES];
  logic [COORD_W-1:0] pos_q  [LANES];
  logic [COORD_W-1:0] new_q  [LANES];
  logic [COORD_W-1:0] res_q  [LANES];
  logic [DIFF_W-1:0]  d_q    [LANES];
  logic [ACC_W-1:0]   mcand_q[LANES];
  logic [DIFF_W-1:0]  mplier_q[LANES];
  logic [ACC_W-1:0]   acc_q  [LANES];
  logic [DREM_W-1:0]  drem_q [LANES];
  logic [SPEED_W-1:0] spd_q;
  logic [ACC_W-1:0]   rad_q;
  logic [ROOT_W-1:0]  root_q;
  logic [SREM_W-1:0]  srem_q;
  logic               snap_q, end_q, pv_q;

  logic [3*COORD_W-1:0] rdata;
  logic                 s_fire, ram_we, pfull, sec_ok, is_last;
  logic [IDXW-1:0]      raddr;

  logic [DIFF_W-1:0]  diff_w [LANES];
  logic [DIFF_W-1:0]  dmag_w [LANES];
  logic [DIFF_W-1:0]  d1mag_w[LANES];
  logic [ACC_W-1:0]   accn_w [LANES];
  logic [DREM_W:0]    dr_w   [LANES];
  logic               dge_w  [LANES];
  logic [COORD_W-1:0] stepn_w[LANES];
  logic [DIFF_W-1:0]  d2_w   [LANES];
  logic [DIFF_W-1:0]  d2mag_w[LANES];
  logic [ACC_W-1:0]   dotm_w [LANES];
  logic [ACC_W-1:0]   sum_w;
  logic [SREM_W+1:0]  srn_w;
  logic [SREM_W+1:0]  trial_w;
  logic               sge_w;
  logic [ROOT_W-1:0]  rootn_w;
  logic [TW-1:0]      trim_ext, scnt_ext;
  logic [IDXW+SEC_W-1:0] sec_ext;

  assign req     = s_axis_tuser;
  assign in_spd  = s_axis_tdata[192 +: SPEED_W];
  assign in_trim = s_axis_tdata[223 +: TRIM_W];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      in_pt[l]  = s_axis_tdata[l*COORD_W +: COORD_W];
      in_pos[l] = s_axis_tdata[(LANES+l)*COORD_W +: COORD_W];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign pfull         = (pcnt_q == CW'(MAX_POINTS));
  assign ram_we        = s_fire && (req == REQ_LOAD) && !pfull;
  assign raddr         = sidx_q + IDXW'(1);
  assign sec_ok        = (scnt_q != '0) && (CW'(sidx_q) < scnt_q);
  assign is_last       = (CW'(sidx_q) == scnt_q - CW'(1));
  assign trim_ext      = TW'(in_trim);
  assign scnt_ext      = TW'(scnt_q);
  assign sec_ext       = {{SEC_W{1'b0}}, sidx_q};

  wpsu_ram #(
    .WIDTH(3 * COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pcnt_q[IDXW-1:0]),
    .wdata_i({in_pt[2], in_pt[1], in_pt[0]}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff_w[l]  = {rdata[l*COORD_W+COORD_W-1], rdata[l*COORD_W +: COORD_W]}
                 - {pos_q[l][COORD_W-1], pos_q[l]};
      dmag_w[l]  = diff_w[l][DIFF_W-1] ? -diff_w[l] : diff_w[l];
      d1mag_w[l] = d_q[l][DIFF_W-1] ? -d_q[l] : d_q[l];
      accn_w[l]  = acc_q[l] + (mplier_q[l][0] ? mcand_q[l] : '0);
      dr_w[l]    = {drem_q[l], acc_q[l][DIV_W-1]};
      dge_w[l]   = (dr_w[l] >= {1'b0, root_q});
      d2_w[l]    = {e_q[l][COORD_W-1], e_q[l]} - {new_q[l][COORD_W-1], new_q[l]};
      d2mag_w[l] = d2_w[l][DIFF_W-1] ? -d2_w[l] : d2_w[l];
      dotm_w[l]  = d2_w[l][DIFF_W-1] ? -{{(ACC_W-DIFF_W){d_q[l][DIFF_W-1]}}, d_q[l]}
                                     :  {{(ACC_W-DIFF_W){d_q[l][DIFF_W-1]}}, d_q[l]};
    end
  end

  always_comb begin
    logic [ROOT_W-1:0] qs;
    logic [STEP_W-1:0] n;
    qs = '0;
    n  = '0;
    for (int l = 0; l < LANES; l++) begin
      if ((|acc_q[l][DIV_W-1:ROOT_W]) || (acc_q[l][ROOT_W-1] && (|acc_q[l][ROOT_W-2:0]))) begin
        qs = {1'b1, {(ROOT_W-1){1'b0}}};
      end else begin
        qs = acc_q[l][ROOT_W-1:0];
      end
      if (d_q[l][DIFF_W-1]) begin
        n = {{(STEP_W-COORD_W){pos_q[l][COORD_W-1]}}, pos_q[l]} - STEP_W'(qs);
      end else begin
        n = {{(STEP_W-COORD_W){pos_q[l][COORD_W-1]}}, pos_q[l]} + STEP_W'(qs);
      end
      if (!n[STEP_W-1] && (|n[STEP_W-2:COORD_W-1])) begin
        stepn_w[l] = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (n[STEP_W-1] && !(&n[STEP_W-2:COORD_W-1])) begin
        stepn_w[l] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        stepn_w[l] = n[COORD_W-1:0];
      end
    end
  end

  assign sum_w   = acc_q[0] + acc_q[1] + acc_q[2];
  assign srn_w   = {srem_q, rad_q[ACC_W-1 -: 2]};
  assign trial_w = (SREM_W+2)'({root_q, 2'b01});
  assign sge_w   = (srn_w >= trial_w);
  assign rootn_w = {root_q[ROOT_W-2:0], sge_w};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = (req == REQ_MOVE && sec_ok) ? S_RD : S_DONE;
        end
      end
      S_RD:   state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = (sel_q == SEL_SPD) ? S_DIV : S_COMB;
        end
      end
      S_COMB: state_d = (sel_q == SEL_SQ) ? S_SQRT : S_FIN;
      S_SQRT: begin
        if (cnt_q == SQRT_LAST) begin
          state_d = (rootn_w == '0) ? S_FIN : S_MUL;
        end
      end
      S_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_STEP;
        end
      end
      S_STEP: state_d = S_D2;
      S_D2:   state_d = S_MUL;
      S_FIN:  state_d = S_DONE;
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sel_q     <= SEL_SQ;
      cnt_q     <= '0;
      pcnt_q    <= '0;
      scnt_q    <= '0;
      sidx_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            case (req)
              REQ_LOAD: begin
                if (!pfull) begin
                  pcnt_q <= pcnt_q + CW'(1);
                  scnt_q <= pcnt_q;
                end
              end
              REQ_TRIM: begin
                scnt_q <= (trim_ext >= scnt_ext) ? '0 : scnt_q - trim_ext[CW-1:0];
              end
              REQ_CLEAR: begin
                pcnt_q <= '0;
                scnt_q <= '0;
                sidx_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          cnt_q <= '0;
          sel_q <= SEL_SQ;
        end
        S_MUL:  cnt_q <= (cnt_q == MUL_LAST) ? '0 : cnt_q + 6'd1;
        S_COMB: cnt_q <= '0;
        S_SQRT: begin
          cnt_q <= (cnt_q == SQRT_LAST) ? '0 : cnt_q + 6'd1;
          sel_q <= SEL_SPD;
        end
        S_DIV:  cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + 6'd1;
        S_D2: begin
          cnt_q <= '0;
          sel_q <= SEL_DOT;
        end
        S_FIN: begin
          if (snap_q && !is_last) begin
            sidx_q <= sidx_q + IDXW'(1);
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        spd_q  <= in_spd;
        snap_q <= 1'b0;
        end_q  <= 1'b0;
        pv_q   <= 1'b0;
        for (int l = 0; l < LANES; l++) begin
          pos_q[l] <= in_pos[l];
          res_q[l] <= (req == REQ_MOVE) ? in_pos[l] : '0;
        end
      end
      S_DIFF: begin
        for (int l = 0; l < LANES; l++) begin
          e_q[l]      <= rdata[l*COORD_W +: COORD_W];
          d_q[l]      <= diff_w[l];
          mcand_q[l]  <= ACC_W'(dmag_w[l]);
          mplier_q[l] <= dmag_w[l];
          acc_q[l]    <= '0;
        end
      end
      S_MUL: begin
        for (int l = 0; l < LANES; l++) begin
          acc_q[l]    <= accn_w[l];
          mcand_q[l]  <= {mcand_q[l][ACC_W-2:0], 1'b0};
          mplier_q[l] <= {1'b0, mplier_q[l][DIFF_W-1:1]};
          drem_q[l]   <= '0;
        end
      end
      S_COMB: begin
        rad_q  <= sum_w;
        root_q <= '0;
        srem_q <= '0;
        snap_q <= sum_w[ACC_W-1] || (sum_w == '0);
      end
      S_SQRT: begin
        srem_q <= sge_w ? SREM_W'(srn_w - trial_w) : SREM_W'(srn_w);
        root_q <= rootn_w;
        rad_q  <= {rad_q[ACC_W-3:0], 2'b00};
        snap_q <= (rootn_w == '0);
        for (int l = 0; l < LANES; l++) begin
          mcand_q[l]  <= ACC_W'(d1mag_w[l]);
          mplier_q[l] <= DIFF_W'(spd_q);
          acc_q[l]    <= '0;
        end
      end
      S_DIV: begin
        for (int l = 0; l < LANES; l++) begin
          drem_q[l] <= dge_w[l] ? DREM_W'(dr_w[l] - {1'b0, root_q}) : DREM_W'(dr_w[l]);
          acc_q[l]  <= {acc_q[l][ACC_W-1:DIV_W], acc_q[l][DIV_W-2:0], dge_w[l]};
        end
      end
      S_STEP: begin
        for (int l = 0; l < LANES; l++) begin
          new_q[l] <= stepn_w[l];
        end
      end
      S_D2: begin
        for (int l = 0; l < LANES; l++) begin
          mcand_q[l]  <= dotm_w[l];
          mplier_q[l] <= d2mag_w[l];
          acc_q[l]    <= '0;
        end
      end
      S_FIN: begin
        pv_q  <= 1'b1;
        end_q <= snap_q && is_last;
        for (int l = 0; l < LANES; l++) begin
          res_q[l] <= snap_q ? e_q[l] : new_q[l];
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {pv_q, sec_ext[SEC_W-1:0], end_q, res_q[2], res_q[1], res_q[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done");

  a_end_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[103])
    else $error("path end without valid section");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scnt_q < pcnt_q) || (scnt_q == '0))
    else $error("section count exceeds point count");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q != S_IDLE) && !s_axis_tready)
    else $error("word taken without leaving idle");
`endif

endmodule

// ===== hdl/wpsu_ram.sv =====
module wpsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
